### rtl/bdq_pkg.sv
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_POP_FRONT  = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        t_status               status;
        logic                  found;
        logic [OUT_CNT_W-1:0]  count;
    } t_out_word;

    // Ring position base + off, with off no larger than the capacity.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(CAPACITY)) begin
            s = s - (CNT_W+1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

    // Count as reported on the result word: low five bits.
    function automatic logic [OUT_CNT_W-1:0] out_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+OUT_CNT_W-1:0] w;
        w = (CNT_W+OUT_CNT_W)'(c);
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

### rtl/bdq_ram.sv
module bdq_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [bdq_pkg::IDX_W-1:0]  i_waddr,
    input  logic [bdq_pkg::DATA_W-1:0] i_wdata,
    input  logic [bdq_pkg::IDX_W-1:0]  i_raddr,
    output logic [bdq_pkg::DATA_W-1:0] o_rdata
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

### rtl/bounded_deque_with_search.sv
// Channel   Direction  Handshake              Word
// command   in         start high, busy low   i_item  (cmd, value)
// result    out        o_valid, one cycle     o_result (status, found, count)
//
// Push, pop, unused codes and a search of an empty deque leave busy low; the
// result word shows in the next cycle and a new command may be accepted in that cycle.
// A search holds busy while it scans the held entries from the front, one
// entry a cycle through the single read port of the entry memory, and ends
// at the first match or at the last held entry.
// Synchronous active-low reset empties the deque; entries are not cleared.
// The receiver cannot stall: each result word is valid for one cycle only.
module bounded_deque_with_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  bdq_pkg::t_in_word  i_item,
    output logic               busy,
    output logic               o_valid,
    output bdq_pkg::t_out_word o_result
);
    import bdq_pkg::*;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_front, n_front;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_issue, n_issue;
    logic [DATA_W-1:0]   r_value, n_value;
    logic                r_valid, n_valid;
    t_out_word           r_result, n_result;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [IDX_W-1:0]    mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;
    logic [IDX_W-1:0]    front_dec;
    logic                full;
    logic                empty;

    bdq_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_item.value),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign full      = (r_count == CNT_W'(CAPACITY));
    assign empty     = (r_count == '0);
    assign front_dec = (r_front == '0) ? IDX_W'(CAPACITY - 1) : r_front - IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_issue <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_issue <= n_issue;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_result <= n_result;
    end

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_issue   = r_issue;
        n_value   = r_value;
        n_valid   = 1'b0;
        n_result  = r_result;
        mem_we    = 1'b0;
        mem_waddr = ring_add(r_front, r_count);
        mem_raddr = r_front;
        busy      = (r_state == S_SEARCH);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_value         = i_item.value;
                    n_valid         = 1'b1;
                    n_result.status = ST_OK;
                    n_result.found  = 1'b0;
                    case (i_item.cmd)
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_result.status = ST_FULL;
                            end else begin
                                n_front   = front_dec;
                                mem_waddr = front_dec;
                                mem_we    = 1'b1;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                n_result.status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_front = ring_add(r_front, CNT_W'(1));
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        CMD_SEARCH: begin
                            // read the front entry now, compare from next cycle
                            if (!empty) begin
                                n_valid   = 1'b0;
                                n_state   = S_SEARCH;
                                n_issue   = CNT_W'(1);
                                mem_raddr = r_front;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_result.count = out_count(n_count);
                end
            end
            S_SEARCH: begin
                if (mem_rdata == r_value || r_issue == r_count) begin
                    n_valid         = 1'b1;
                    n_state         = S_IDLE;
                    n_result.status = ST_OK;
                    n_result.found  = (mem_rdata == r_value);
                    n_result.count  = out_count(r_count);
                end else begin
                    // advance to the next held entry
                    mem_raddr = ring_add(r_front, r_issue);
                    n_issue   = r_issue + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !mem_we)
        else $error("memory written during search");

    a_search_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_SEARCH && !empty) |=> busy && !o_valid)
        else $error("search on non-empty deque did not start scan");

    a_issue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_issue != '0 && r_issue <= r_count))
        else $error("scan offset out of range");

    a_done_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("search ended without a result word");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_front) && $stable(r_count))
        else $error("deque state changed during search");
`endif

endmodule
